// File: design/xsd_pkg.sv
// Package for the x86 subset instruction decoder.
// Request and result types, operation codes and opcode byte constants.
// No dependencies.
package xsd_pkg;

    typedef struct packed {
        logic [31:0] address;
        logic [63:0] instruction_bytes;
    } t_dec_req;

    typedef struct packed {
        logic              decode_error;
        logic [4:0]        operation;
        logic signed [3:0] dest_register;
        logic signed [3:0] source_register;
        logic [31:0]       immediate;
        logic [3:0]        length;
        logic              modrm_present;
        logic [2:0]        modrm_reg_field;
        logic [2:0]        modrm_rm_field;
    } t_dec_res;

    localparam logic [4:0] OP_NOP    = 5'd0;
    localparam logic [4:0] OP_HLT    = 5'd1;
    localparam logic [4:0] OP_IN     = 5'd2;
    localparam logic [4:0] OP_OUT    = 5'd3;
    localparam logic [4:0] OP_JMP    = 5'd4;
    localparam logic [4:0] OP_RET    = 5'd5;
    localparam logic [4:0] OP_INT    = 5'd6;
    localparam logic [4:0] OP_IRET   = 5'd7;
    localparam logic [4:0] OP_STOSB  = 5'd8;
    localparam logic [4:0] OP_CMP    = 5'd9;
    localparam logic [4:0] OP_TEST   = 5'd10;
    localparam logic [4:0] OP_JZ     = 5'd11;
    localparam logic [4:0] OP_JNZ    = 5'd12;
    localparam logic [4:0] OP_ADD    = 5'd13;
    localparam logic [4:0] OP_SUB    = 5'd14;
    localparam logic [4:0] OP_INC    = 5'd15;
    localparam logic [4:0] OP_DEC    = 5'd16;
    localparam logic [4:0] OP_MOV    = 5'd17;
    localparam logic [4:0] OP_PUSH   = 5'd18;
    localparam logic [4:0] OP_POP    = 5'd19;
    localparam logic [4:0] OP_MOV_CR = 5'd20;

    localparam logic [7:0] OPC_ADD_RM_R = 8'h01;
    localparam logic [7:0] OPC_ADD_R_RM = 8'h03;
    localparam logic [7:0] OPC_ESC      = 8'h0F;
    localparam logic [7:0] OPC_SUB_RM_R = 8'h29;
    localparam logic [7:0] OPC_SUB_R_RM = 8'h2B;
    localparam logic [7:0] OPC_CMP_AL   = 8'h3C;
    localparam logic [7:0] OPC_JZ       = 8'h74;
    localparam logic [7:0] OPC_JNZ      = 8'h75;
    localparam logic [7:0] OPC_GRP_IMM8 = 8'h83;
    localparam logic [7:0] OPC_NOP      = 8'h90;
    localparam logic [7:0] OPC_TEST_AL  = 8'hA8;
    localparam logic [7:0] OPC_STOSB    = 8'hAA;
    localparam logic [7:0] OPC_RET      = 8'hC3;
    localparam logic [7:0] OPC_INT      = 8'hCD;
    localparam logic [7:0] OPC_IRET     = 8'hCF;
    localparam logic [7:0] OPC_IN       = 8'hE4;
    localparam logic [7:0] OPC_OUT      = 8'hE6;
    localparam logic [7:0] OPC_JMP      = 8'hEB;
    localparam logic [7:0] OPC_HLT      = 8'hF4;
    localparam logic [7:0] OPC2_MOV_FROM_CR = 8'h20;
    localparam logic [7:0] OPC2_MOV_TO_CR   = 8'h22;

    localparam logic [7:0] OPC_INC_BASE   = 8'h40;
    localparam logic [7:0] OPC_DEC_BASE   = 8'h48;
    localparam logic [7:0] OPC_PUSH_BASE  = 8'h50;
    localparam logic [7:0] OPC_POP_BASE   = 8'h58;
    localparam logic [7:0] OPC_MOV8_BASE  = 8'hB0;
    localparam logic [7:0] OPC_MOV32_BASE = 8'hB8;

    localparam logic [2:0] GRP_REG_ADD = 3'd0;
    localparam logic [2:0] GRP_REG_SUB = 3'd5;
    localparam logic [1:0] MOD_REG     = 2'b11;

    localparam logic signed [3:0] REG_NONE = 4'sb1111;
    localparam logic signed [3:0] REG_AL   = 4'sb0000;

    localparam logic [1:0] CFG_ADDR_MEM_SIZE = 2'd0;

endpackage

// File: design/xsd_decode.sv
// Combinational decode of one instruction window against the memory size.
// Depends on xsd_pkg.
module xsd_decode (
    input  xsd_pkg::t_dec_req i_req,
    input  logic [31:0]       i_mem_size,
    output xsd_pkg::t_dec_res o_res
);
    import xsd_pkg::*;

    logic [32:0] room_full;
    logic [31:0] room;
    logic        base_ok;
    logic [7:0]  b0, b1, b2, b3, b4;
    logic        modrm1_ok, modrm2_ok;
    logic [1:0]  mod1;
    logic [2:0]  reg1, rm1;

    assign room_full = {1'b0, i_mem_size} - {1'b0, i_req.address};
    assign room      = room_full[31:0];
    assign base_ok   = !room_full[32] && (room != 32'd0) && (i_mem_size >= 32'd2);

    assign b0 = i_req.instruction_bytes[7:0];
    assign b1 = (room > 32'd1) ? i_req.instruction_bytes[15:8]  : 8'h00;
    assign b2 = (room > 32'd2) ? i_req.instruction_bytes[23:16] : 8'h00;
    assign b3 = (room > 32'd3) ? i_req.instruction_bytes[31:24] : 8'h00;
    assign b4 = (room > 32'd4) ? i_req.instruction_bytes[39:32] : 8'h00;

    assign modrm1_ok = room >= 32'd7;
    assign modrm2_ok = room >= 32'd8;
    assign mod1 = b1[7:6];
    assign reg1 = b1[5:3];
    assign rm1  = b1[2:0];

    always_comb begin
        o_res.decode_error    = 1'b1;
        o_res.operation       = OP_NOP;
        o_res.dest_register   = REG_NONE;
        o_res.source_register = REG_NONE;
        o_res.immediate       = 32'd0;
        o_res.length          = 4'd1;
        o_res.modrm_present   = 1'b0;
        o_res.modrm_reg_field = 3'd0;
        o_res.modrm_rm_field  = 3'd0;
        if (base_ok) begin
            unique case (b0) inside
                OPC_ESC: begin
                    if ((b1 == OPC2_MOV_FROM_CR || b1 == OPC2_MOV_TO_CR) && modrm2_ok
                        && b2[7:6] == MOD_REG) begin
                        o_res.decode_error    = 1'b0;
                        o_res.operation       = OP_MOV_CR;
                        o_res.dest_register   = {1'b0, b2[5:3]};
                        o_res.source_register = {1'b0, b2[2:0]};
                        o_res.immediate       = {31'd0, b1 == OPC2_MOV_TO_CR};
                        o_res.length          = 4'd3;
                        o_res.modrm_present   = 1'b1;
                        o_res.modrm_reg_field = b2[5:3];
                        o_res.modrm_rm_field  = b2[2:0];
                    end
                end
                OPC_NOP, OPC_HLT, OPC_RET, OPC_IRET, OPC_STOSB: begin
                    o_res.decode_error = 1'b0;
                    unique case (b0)
                        OPC_NOP:  o_res.operation = OP_NOP;
                        OPC_HLT:  o_res.operation = OP_HLT;
                        OPC_RET:  o_res.operation = OP_RET;
                        OPC_IRET: o_res.operation = OP_IRET;
                        default:  o_res.operation = OP_STOSB;
                    endcase
                end
                OPC_IN, OPC_OUT, OPC_INT: begin
                    o_res.decode_error = 1'b0;
                    o_res.immediate    = {24'd0, b1};
                    o_res.length       = 4'd2;
                    unique case (b0)
                        OPC_IN:  o_res.operation = OP_IN;
                        OPC_OUT: o_res.operation = OP_OUT;
                        default: o_res.operation = OP_INT;
                    endcase
                end
                OPC_CMP_AL, OPC_TEST_AL: begin
                    o_res.decode_error  = 1'b0;
                    o_res.operation     = (b0 == OPC_CMP_AL) ? OP_CMP : OP_TEST;
                    o_res.dest_register = REG_AL;
                    o_res.immediate     = {24'd0, b1};
                    o_res.length        = 4'd2;
                end
                OPC_JMP, OPC_JZ, OPC_JNZ: begin
                    o_res.decode_error = 1'b0;
                    o_res.immediate    = {{24{b1[7]}}, b1};
                    o_res.length       = 4'd2;
                    unique case (b0)
                        OPC_JMP: o_res.operation = OP_JMP;
                        OPC_JZ:  o_res.operation = OP_JZ;
                        default: o_res.operation = OP_JNZ;
                    endcase
                end
                OPC_ADD_RM_R, OPC_ADD_R_RM, OPC_SUB_RM_R, OPC_SUB_R_RM, OPC_GRP_IMM8: begin
                    if (modrm1_ok && mod1 == MOD_REG) begin
                        if (b0 == OPC_GRP_IMM8) begin
                            if (reg1 == GRP_REG_ADD || reg1 == GRP_REG_SUB) begin
                                o_res.decode_error  = 1'b0;
                                o_res.operation     = (reg1 == GRP_REG_ADD) ? OP_ADD : OP_SUB;
                                o_res.dest_register = {1'b0, rm1};
                                o_res.immediate     = {{24{b2[7]}}, b2};
                                o_res.length        = 4'd3;
                            end
                        end else begin
                            o_res.decode_error = 1'b0;
                            o_res.operation    = (b0 == OPC_ADD_RM_R || b0 == OPC_ADD_R_RM)
                                                 ? OP_ADD : OP_SUB;
                            o_res.length       = 4'd2;
                            if (b0 == OPC_ADD_RM_R || b0 == OPC_SUB_RM_R) begin
                                o_res.dest_register   = {1'b0, rm1};
                                o_res.source_register = {1'b0, reg1};
                            end else begin
                                o_res.dest_register   = {1'b0, reg1};
                                o_res.source_register = {1'b0, rm1};
                            end
                        end
                        if (!o_res.decode_error) begin
                            o_res.modrm_present   = 1'b1;
                            o_res.modrm_reg_field = reg1;
                            o_res.modrm_rm_field  = rm1;
                        end
                    end
                end
                [OPC_INC_BASE:OPC_INC_BASE + 8'd7]: begin
                    o_res.decode_error  = 1'b0;
                    o_res.operation     = OP_INC;
                    o_res.dest_register = {1'b0, b0[2:0]};
                end
                [OPC_DEC_BASE:OPC_DEC_BASE + 8'd7]: begin
                    o_res.decode_error  = 1'b0;
                    o_res.operation     = OP_DEC;
                    o_res.dest_register = {1'b0, b0[2:0]};
                end
                [OPC_PUSH_BASE:OPC_PUSH_BASE + 8'd7]: begin
                    o_res.decode_error  = 1'b0;
                    o_res.operation     = OP_PUSH;
                    o_res.dest_register = {1'b0, b0[2:0]};
                end
                [OPC_POP_BASE:OPC_POP_BASE + 8'd7]: begin
                    o_res.decode_error  = 1'b0;
                    o_res.operation     = OP_POP;
                    o_res.dest_register = {1'b0, b0[2:0]};
                end
                [OPC_MOV8_BASE:OPC_MOV8_BASE + 8'd7]: begin
                    o_res.decode_error  = 1'b0;
                    o_res.operation     = OP_MOV;
                    o_res.dest_register = {1'b0, b0[2:0]};
                    o_res.immediate     = {24'd0, b1};
                    o_res.length        = 4'd2;
                end
                [OPC_MOV32_BASE:OPC_MOV32_BASE + 8'd7]: begin
                    o_res.decode_error  = 1'b0;
                    o_res.operation     = OP_MOV;
                    o_res.dest_register = {1'b0, b0[2:0]};
                    o_res.immediate     = {b4, b3, b2, b1};
                    o_res.length        = 4'd5;
                end
                default: begin
                    o_res.decode_error = 1'b1;
                end
            endcase
        end
    end

endmodule

// File: design/x86_subset_instruction_decoder_top.sv
// Top level of the x86 subset instruction decoder: request and result
// channels, the memory size register and the two pipeline registers.
// Depends on xsd_pkg and xsd_decode.
//
// Usage:
//   A request carries an instruction address and the eight memory bytes from
//   that address. It is taken when i_in_valid is high and o_in_stall is low.
//   Each request gives exactly one result on o_out_res, taken when
//   o_out_valid is high and i_out_stall is low.
//   A request passes through the request register, then the decode logic
//   loads the result register.
//   Throughput is one request per cycle while the receiver does not stall,
//   set by the single decode pass between the two registers.
//   Reset clears both valid flags and sets the memory size to zero, so every
//   request decodes as an error until the size is written over the APB port.
//   While the receiver stalls, the result holds and one more request may sit
//   in the request register; o_in_stall then rises until the result drains.
//   Write the memory size only while no request is in flight.
module x86_subset_instruction_decoder_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  xsd_pkg::t_dec_req i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output xsd_pkg::t_dec_res o_out_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import xsd_pkg::*;

    logic        r_in_valid;
    t_dec_req    r_in_req;
    logic        r_out_valid;
    t_dec_res    r_out_res;
    logic [31:0] r_mem_size;
    t_dec_res    n_out_res;
    logic        out_load;
    logic        in_load;

    xsd_decode u_decode (
        .i_req      (r_in_req),
        .i_mem_size (r_mem_size),
        .o_res      (n_out_res)
    );

    assign out_load   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !out_load;
    assign in_load    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_load || out_load) begin
                r_in_valid <= in_load;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_req <= i_in_req;
        end
        if (out_load && r_in_valid) begin
            r_out_res <= n_out_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_size <= 32'd0;
        end else if (psel && penable && pwrite && paddr == CFG_ADDR_MEM_SIZE) begin
            r_mem_size <= pwdata;
        end
    end

    assign pready      = 1'b1;
    assign prdata      = (paddr == CFG_ADDR_MEM_SIZE) ? r_mem_size : 32'd0;
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_res.decode_error |->
            o_out_res.length == 4'd1 && o_out_res.operation == OP_NOP
            && o_out_res.immediate == 32'd0 && !o_out_res.modrm_present)
        else $error("error result not in canonical form");

    a_modrm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_res.modrm_present |->
            o_out_res.modrm_reg_field == 3'd0 && o_out_res.modrm_rm_field == 3'd0)
        else $error("modrm fields set without modrm byte");

    a_cr_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_res.operation == OP_MOV_CR && !o_out_res.decode_error |->
            o_out_res.modrm_present && o_out_res.length == 4'd3)
        else $error("control register move with wrong form");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && out_load |=> o_out_valid)
        else $error("pending request did not reach result register");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && i_out_stall |-> o_in_stall)
        else $error("request accepted with full pipeline");

endmodule
